// File: design/png_scanline_unfilter_unit_defines.svh
// assertion macros for the png scanline unfilter unit
// used by the top level only; no other dependencies
`ifndef PNG_SCANLINE_UNFILTER_UNIT_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PNGSU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PNGSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pngsu_pkg.sv
// shared types and constants for the png scanline unfilter unit
// no dependencies
package pngsu_pkg;

  // default sizing of the line store and the left-neighbour history
  localparam int DEF_MAX_LINE_BYTES  = 8192;
  localparam int DEF_MAX_PIXEL_BYTES = 4;

  // configuration register widths
  localparam int LINE_BYTES_W = 14;
  localparam int BPP_W        = 3;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 14;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_BYTES = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BPP        = 1'b1;

  // png filter method 0 filter types
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

endpackage

// File: design/pngsu_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module pngsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/pngsu_predict.sv
// filter predictor and byte reconstruction for png filter method 0
// depends on pngsu_pkg
module pngsu_predict
  import pngsu_pkg::*;
(
  input  filt_t      kind,
  input  logic [7:0] filt_byte,
  input  logic [7:0] left,
  input  logic [7:0] up,
  input  logic [7:0] up_left,
  output logic [7:0] recon
);

  logic signed [9:0] d_pa;
  logic signed [9:0] d_pb;
  logic signed [9:0] d_pc;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [7:0]        paeth;
  logic [8:0]        avg_sum;
  logic [7:0]        pred;

  // paeth distances, ties go to left, then up, then up-left
  always_comb begin
    d_pa = $signed({2'b00, up}) - $signed({2'b00, up_left});
    d_pb = $signed({2'b00, left}) - $signed({2'b00, up_left});
    d_pc = $signed({2'b00, left}) + $signed({2'b00, up})
         - $signed({1'b0, up_left, 1'b0});
    pa = d_pa[9] ? 10'(-d_pa) : 10'(d_pa);
    pb = d_pb[9] ? 10'(-d_pb) : 10'(d_pb);
    pc = d_pc[9] ? 10'(-d_pc) : 10'(d_pc);
    if (pa <= pb && pa <= pc) begin
      paeth = left;
    end else if (pb <= pc) begin
      paeth = up;
    end else begin
      paeth = up_left;
    end
  end

  // predictor select and modulo-256 add
  always_comb begin
    avg_sum = {1'b0, left} + {1'b0, up};
    unique case (kind)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
    recon = filt_byte + pred;
  end

endmodule

// File: design/png_scanline_unfilter_unit.sv
// png scanline unfilter unit: filter method 0 reconstruction, one byte per item
// depends on pngsu_pkg, pngsu_ram, pngsu_predict and the assertion macro header
//
// Usage:
//   Input channel (in_valid / in_stall) carries data_byte and image_start. The
//   first byte of each row is its filter type and gives no result; every other
//   byte gives one result on the output channel (out_valid / out_stall) with
//   pixel_byte and row_end. A filter type above 4 gives one result with
//   bad_filter set, after which bytes are dropped until image_start.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) sets line_bytes
//   and the pixel stride; cfg_ready is always high, write only while idle.
//   Path: an accepted byte goes into the input register, then into the result
//   register, from which it is taken. Throughput is one byte per cycle while
//   out_stall is low; the limit is the loop from the left-byte history through
//   the predictor and back, and the line store reads the byte above in advance.
//   Reset: synchronous; registers go to line_bytes 1, pixel stride 1, the
//   histories clear and the unit waits for a filter type byte. The line store
//   is not cleared; the first row of an image reads zero above instead.
//   Stall: while out_stall holds a result, one more byte is taken into the
//   input register; items that give no result still pass through.
`include "png_scanline_unfilter_unit_defines.svh"

module png_scanline_unfilter_unit
  import pngsu_pkg::*;
#(
  parameter int MAX_LINE_BYTES  = DEF_MAX_LINE_BYTES,
  parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   image_start,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             pixel_byte,
  output logic                   row_end,
  output logic                   bad_filter,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W  = $clog2(MAX_LINE_BYTES);
  localparam int LEN_W  = $clog2(MAX_LINE_BYTES + 1);
  localparam int PIX_W  = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int PIX_IW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // configuration registers
  logic [LINE_BYTES_W-1:0] line_bytes;
  logic [BPP_W-1:0]        pixel_stride;

  // input register
  logic       s0_valid;
  logic [7:0] s0_data;
  logic       s0_start;

  // unfilter state
  logic [COL_W-1:0] column;
  logic [COL_W-1:0] column_next;
  logic             awaiting;
  filt_t            filter_kind;
  logic             first_row;
  logic             halted;
  logic [7:0]       left_hist [MAX_PIXEL_BYTES];
  logic [7:0]       upl_hist  [MAX_PIXEL_BYTES];

  // line store bypass
  logic             byp_hit;
  logic [7:0]       byp_data;
  logic [7:0]       ram_rdata;

  // combinational
  logic [LEN_W-1:0]  eff_len;
  logic [PIX_W-1:0]  eff_bpp;
  logic [PIX_IW-1:0] bpp_idx;
  logic              halted_eff;
  logic              awaiting_eff;
  logic              first_eff;
  logic              is_bad;
  logic              is_data;
  logic              produces;
  logic              out_free;
  logic              advance;
  logic              row_last;
  logic              has_left;
  logic [7:0]        a_byte;
  logic [7:0]        b_byte;
  logic [7:0]        c_byte;
  logic [7:0]        recon;
  logic              ram_we;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes   <= LINE_BYTES_W'(1);
      pixel_stride <= BPP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_BYTES: line_bytes   <= LINE_BYTES_W'(cfg_data);
        REG_BPP:        pixel_stride <= cfg_data[BPP_W-1:0];
        default:        ;
      endcase
    end
  end

  // clamp registers to the supported range
  always_comb begin
    if (line_bytes == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(line_bytes) > 32'(MAX_LINE_BYTES)) begin
      eff_len = LEN_W'(MAX_LINE_BYTES);
    end else begin
      eff_len = LEN_W'(line_bytes);
    end
    if (pixel_stride == '0) begin
      eff_bpp = PIX_W'(1);
    end else if (32'(pixel_stride) > 32'(MAX_PIXEL_BYTES)) begin
      eff_bpp = PIX_W'(MAX_PIXEL_BYTES);
    end else begin
      eff_bpp = PIX_W'(pixel_stride);
    end
    bpp_idx = PIX_IW'(eff_bpp - PIX_W'(1));
  end

  // item classification and flow control
  always_comb begin
    halted_eff   = s0_start ? 1'b0 : halted;
    awaiting_eff = s0_start ? 1'b1 : awaiting;
    first_eff    = s0_start ? 1'b1 : first_row;
    is_bad       = awaiting_eff && (s0_data > 8'(FILT_PAETH));
    is_data      = !halted_eff && !awaiting_eff;
    produces     = !halted_eff && (!awaiting_eff || is_bad);
    out_free     = !out_valid || !out_stall;
    advance      = s0_valid && (out_free || !produces);
    in_stall     = s0_valid && !advance;
  end

  // neighbours of the current byte
  always_comb begin
    has_left = 32'(column) >= 32'(eff_bpp);
    a_byte   = has_left ? left_hist[bpp_idx] : 8'd0;
    c_byte   = has_left ? upl_hist[bpp_idx] : 8'd0;
    b_byte   = first_eff ? 8'd0 : (byp_hit ? byp_data : ram_rdata);
    row_last = (32'(column) + 32'd1) >= 32'(eff_len);
    ram_we   = advance && is_data;
  end

  pngsu_predict u_predict (
    .kind      (filter_kind),
    .filt_byte (s0_data),
    .left      (a_byte),
    .up        (b_byte),
    .up_left   (c_byte),
    .recon     (recon)
  );

  // column for the next item, also the line store read address
  always_comb begin
    column_next = column;
    if (advance) begin
      if (s0_start || (is_data && row_last) || (!halted_eff && awaiting_eff)) begin
        column_next = '0;
      end else if (is_data) begin
        column_next = column + COL_W'(1);
      end
    end
  end

  pngsu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LINE_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (column),
    .wdata (recon),
    .raddr (column_next),
    .rdata (ram_rdata)
  );

  // forward a write that lands on the address read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= ram_we && (column == column_next);
    end
    byp_data <= recon;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s0_valid <= 1'b1;
    end else if (advance) begin
      s0_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      s0_data  <= data_byte;
      s0_start <= image_start;
    end
  end

  // row and image state
  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      awaiting    <= 1'b1;
      filter_kind <= FILT_NONE;
      first_row   <= 1'b1;
      halted      <= 1'b0;
    end else if (advance) begin
      column <= column_next;
      if (!halted_eff) begin
        if (awaiting_eff) begin
          first_row <= first_eff;
          if (is_bad) begin
            halted   <= 1'b1;
            awaiting <= 1'b1;
          end else begin
            halted      <= 1'b0;
            awaiting    <= 1'b0;
            filter_kind <= filt_t'(s0_data[2:0]);
          end
        end else if (row_last) begin
          awaiting  <= 1'b1;
          first_row <= 1'b0;
        end
      end
    end
  end

  // left and above-left histories, newest first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist[k] <= 8'd0;
        upl_hist[k]  <= 8'd0;
      end
    end else if (advance) begin
      if (s0_start || (!halted_eff && awaiting_eff)) begin
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          left_hist[k] <= 8'd0;
          upl_hist[k]  <= 8'd0;
        end
      end else if (is_data) begin
        for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
          left_hist[k] <= left_hist[k-1];
          upl_hist[k]  <= upl_hist[k-1];
        end
        left_hist[0] <= recon;
        upl_hist[0]  <= b_byte;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produces) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && produces) begin
      pixel_byte <= is_bad ? 8'd0 : recon;
      row_end    <= is_bad ? 1'b0 : row_last;
      bad_filter <= is_bad;
    end
  end

  // checks
  `PNGSU_ASSERT_SAME(a_err_result_clean, clk, rst, out_valid && bad_filter,
                     pixel_byte == 8'd0 && !row_end, "error result carries data")
  `PNGSU_ASSERT_SAME(a_halt_waits_filter, clk, rst, halted, awaiting,
                     "halted while inside a row")
  `PNGSU_ASSERT_NEXT(a_row_end_wraps, clk, rst, advance && is_data && row_last,
                     awaiting && column == '0, "row end did not restart the row")
  `PNGSU_ASSERT_SAME(a_bypass_source, clk, rst, byp_hit, $past(ram_we),
                     "line store bypass without a write")

endmodule

// File: bench/png_scanline_unfilter_unit_tb.sv
// self-checking testbench for png_scanline_unfilter_unit: a directed pass, then random scanline
// streams under several line widths and pixel sizes, each result checked against a byte model
// depends on pngsu_pkg and the png_scanline_unfilter_unit rtl
module png_scanline_unfilter_unit_tb;
  import pngsu_pkg::*;

  localparam int MAX_LINE = DEF_MAX_LINE_BYTES;
  localparam int MAX_PIX  = DEF_MAX_PIXEL_BYTES;
  localparam int HOLD_AT  = 120;
  localparam int HOLD_LEN = 200;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       bad;
  } pixel_result_t;

  // byte-level model of the unfilter datapath plus the queue of pixels it predicts
  class unfilter_scoreboard;
    int unsigned   line_reg;
    int unsigned   pix_reg;
    byte unsigned  prior_row [MAX_LINE];
    byte unsigned  left_hist [MAX_PIX];
    byte unsigned  above_left_hist [MAX_PIX];
    int unsigned   column;
    int unsigned   hi_water;
    bit            awaiting;
    bit            first_row;
    bit            halted;
    filt_t         kind;
    int            errors;
    pixel_result_t expected_pixels [$];

    function new();
      line_reg  = 1;
      pix_reg   = 1;
      column    = 0;
      hi_water  = 0;
      awaiting  = 1'b1;
      first_row = 1'b1;
      halted    = 1'b0;
      kind      = FILT_NONE;
      errors    = 0;
      clear_hist();
    endfunction

    function void clear_hist();
      for (int k = 0; k < MAX_PIX; k++) begin
        left_hist[k]       = 8'd0;
        above_left_hist[k] = 8'd0;
      end
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
      if (idx == REG_LINE_BYTES) line_reg = value & 32'h3fff;
      else if (idx == REG_BPP) pix_reg = value & 32'h7;
    endfunction

    // out-of-range register values clamp
    function int unsigned row_len();
      if (line_reg == 0) return 1;
      if (line_reg > MAX_LINE) return MAX_LINE;
      return line_reg;
    endfunction

    function int unsigned pix_step();
      if (pix_reg == 0) return 1;
      if (pix_reg > MAX_PIX) return MAX_PIX;
      return pix_reg;
    endfunction

    // paeth predictor, ties go to left, then above, then above-left
    function int unsigned paeth_pick(int a, int b, int c);
      int pa;
      int pb;
      int pc;
      pa = (b - c) < 0 ? c - b : b - c;
      pb = (a - c) < 0 ? c - a : a - c;
      pc = (a + b - 2 * c) < 0 ? 2 * c - a - b : a + b - 2 * c;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
    endfunction

    // one accepted input item: update the state and queue any pixel it gives
    function void note_byte(logic [7:0] d, logic start);
      int unsigned   len;
      int unsigned   bpp;
      int unsigned   a;
      int unsigned   b;
      int unsigned   c;
      int unsigned   pred;
      logic [7:0]    r;
      pixel_result_t res;
      len = row_len();
      bpp = pix_step();
      if (start) begin
        first_row = 1'b1;
        halted    = 1'b0;
        column    = 0;
        awaiting  = 1'b1;
        clear_hist();
      end
      if (halted) return;
      // filter type byte at row start
      if (awaiting) begin
        if (d > FILT_PAETH) begin
          halted = 1'b1;
          res = '{pixel: 8'd0, row_end: 1'b0, bad: 1'b1};
          expected_pixels.insert(expected_pixels.size(), res);
          return;
        end
        kind     = filt_t'(d[2:0]);
        awaiting = 1'b0;
        column   = 0;
        clear_hist();
        return;
      end
      if (column >= MAX_LINE) column = MAX_LINE - 1;
      a = (column >= bpp) ? left_hist[bpp-1] : 0;
      c = (column >= bpp) ? above_left_hist[bpp-1] : 0;
      b = first_row ? 0 : prior_row[column];
      case (kind)
        FILT_SUB:   pred = a;
        FILT_UP:    pred = b;
        FILT_AVG:   pred = (a + b) >> 1;
        FILT_PAETH: pred = paeth_pick(a, b, c);
        default:    pred = 0;
      endcase
      r = d + pred[7:0];
      for (int k = MAX_PIX - 1; k > 0; k--) begin
        left_hist[k]       = left_hist[k-1];
        above_left_hist[k] = above_left_hist[k-1];
      end
      left_hist[0]       = r;
      above_left_hist[0] = b[7:0];
      prior_row[column]  = r;
      if (column + 1 > hi_water) hi_water = column + 1;
      res = '{pixel: r, row_end: (column + 1 >= len), bad: 1'b0};
      if (res.row_end) begin
        column    = 0;
        awaiting  = 1'b1;
        first_row = 1'b0;
      end else begin
        column++;
      end
      expected_pixels.insert(expected_pixels.size(), res);
    endfunction

    // one accepted output item against the oldest predicted pixel
    function void check_result(logic [7:0] pix, logic rend, logic bad);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected item pixel_byte=%02h row_end=%0b bad_filter=%0b",
                 $time, pix, rend, bad);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (pix !== want.pixel) begin
        $display("%0t: pixel_byte expected %02h actual %02h", $time, want.pixel, pix);
        errors++;
      end
      if (rend !== want.row_end) begin
        $display("%0t: row_end expected %0b actual %0b", $time, want.row_end, rend);
        errors++;
      end
      if (bad !== want.bad) begin
        $display("%0t: bad_filter expected %0b actual %0b", $time, want.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             data_byte = 8'd0;
  logic                   image_start = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             pixel_byte;
  logic                   row_end;
  logic                   bad_filter;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_LINE_BYTES;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  unfilter_scoreboard sb;
  int unsigned taken_bytes = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // directed items: {image_start, data_byte}
  logic [8:0] dir_items [26] = '{
    {1'b1, 5'd0, FILT_NONE},  9'h000, 9'h0ff, 9'h080,
    {1'b0, 5'd0, FILT_UP},    9'h0ff, 9'h001, 9'h07f,
    {1'b0, 5'd0, FILT_PAETH}, 9'h010, 9'h020, 9'h030,
    {1'b0, 5'd0, FILT_AVG},   9'h001, 9'h0fe, 9'h055,
    {1'b0, 5'd0, FILT_SUB},   9'h033,
    {1'b1, 5'd0, FILT_SUB},   9'h0aa, 9'h0cc, 9'h00f,
    9'h005, 9'h009, 9'h1ff, 9'h012
  };

  png_scanline_unfilter_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .image_start (image_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_byte  (pixel_byte),
    .row_end     (row_end),
    .bad_filter  (bad_filter),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(pixel_byte, row_end, bad_filter);
      if (in_valid && !in_stall) begin
        sb.note_byte(data_byte, image_start);
        taken_bytes++;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off once traffic is under way
  always @(negedge clk) begin
    if (!hold_done && taken_bytes >= HOLD_AT) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one item, sometimes with a random gap ahead of it, and wait until it is taken
  task automatic send_byte(logic [7:0] d, logic s);
    int unsigned gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    data_byte   <= d;
    image_start <= s;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [7:0] pick_filter(bit noisy);
    if (noisy && $urandom_range(0, 99) < 8) return 8'($urandom_range(5, 255));
    return 8'($urandom_range(FILT_NONE, FILT_PAETH));
  endfunction

  // next item from the current model state: mostly well-formed rows, some noise
  task automatic choose_item(bit noisy, inout bit force_start,
                             output logic [7:0] d, output logic s, output bit counted);
    int unsigned pick;
    counted = 1'b1;
    s       = 1'b0;
    pick    = $urandom_range(0, 7);
    if (force_start) begin
      s = 1'b1;
      d = pick_filter(noisy);
      force_start = 1'b0;
    end else if (sb.halted) begin
      d = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) begin
        s = 1'b1;
        d = pick_filter(noisy);
      end else begin
        counted = 1'b0;
      end
    end else if (sb.awaiting) begin
      s = noisy && ($urandom_range(0, 7) == 0);
      d = pick_filter(noisy);
    end else if (noisy && $urandom_range(0, 39) == 0) begin
      s = 1'b1;
      d = pick_filter(noisy);
    end else begin
      // extreme bytes often, to provoke paeth ties and wraparound
      d = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom_range(0, 255));
    end
  endtask

  task automatic drain();
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // one configuration setting followed by a random stream
  task automatic run_phase(int unsigned len, int unsigned bpp, int unsigned send_pct,
                           int unsigned recv_pct, int unsigned n, bit noisy);
    int unsigned sent;
    bit          force_start;
    logic [7:0]  d;
    logic        s;
    bit          counted;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    cfg_write(REG_LINE_BYTES, len);
    cfg_write(REG_BPP, bpp);
    // a wider row would read line store bytes never written, so restart the image
    force_start = !sb.first_row && (sb.row_len() > sb.hi_water);
    sent = 0;
    while (sent < n) begin
      choose_item(noisy, force_start, d, s, counted);
      send_byte(d, s);
      if (counted) sent++;
    end
    @(negedge clk);
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: every filter type, extremes, restart mid-row, bad filter types
    send_idle_pct = 19;
    recv_idle_pct = 59;
    cfg_write(REG_LINE_BYTES, 3);
    cfg_write(REG_BPP, 1);
    foreach (dir_items[i]) send_byte(dir_items[i][7:0], dir_items[i][8]);
    @(negedge clk);
    in_valid <= 1'b0;
    drain();

    // sender light, receiver heavy
    run_phase(5, 3, 19, 59, 80, 1'b1);
    run_phase(0, 0, 19, 59, 40, 1'b1);
    run_phase(13, 4, 19, 59, 80, 1'b1);
    // sender heavy, receiver light
    run_phase(12, 7, 59, 19, 60, 1'b1);
    run_phase(4, 2, 59, 19, 50, 1'b1);
    run_phase(2, 1, 59, 19, 50, 1'b1);
    run_phase(9, 5, 59, 19, 60, 1'b1);
    // no idling: the start of an over-long row, then single-byte rows
    run_phase(16383, 4, 0, 0, 30, 1'b0);
    run_phase(1, 1, 0, 0, 60, 1'b1);

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
